[hdl/leb_pkg.sv]
`timescale 1ns / 1ps

package leb_pkg;

  // Default number of character positions in the text store.
  localparam int LEB_STORE_DEPTH = 64;

  // Capacity register value after reset.
  localparam logic [6:0] CAP_RESET = 7'd64;

  // Printable character range accepted by an insert.
  localparam logic [6:0] CHAR_LO = 7'd32;
  localparam logic [6:0] CHAR_HI = 7'd126;

  // Key command codes on the input channel.
  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_HOME   = 3'd1;
  localparam logic [2:0] CMD_END    = 3'd2;
  localparam logic [2:0] CMD_LEFT   = 3'd3;
  localparam logic [2:0] CMD_RIGHT  = 3'd4;
  localparam logic [2:0] CMD_BKSP   = 3'd5;
  localparam logic [2:0] CMD_DEL    = 3'd6;
  localparam logic [2:0] CMD_READ   = 3'd7;

  // Classified operation handed from front to back.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_INS,
    OP_HOME,
    OP_END,
    OP_LEFT,
    OP_RIGHT,
    OP_BKSP,
    OP_DEL,
    OP_READ
  } leb_op_t;

  typedef struct packed {
    leb_op_t    op;
    logic [6:0] ch;
    logic [5:0] idx;
  } leb_item_t;

endpackage

[hdl/leb_if.sv]
`timescale 1ns / 1ps

// Key event channel.
interface leb_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [6:0] char_code;
  logic       is_release;
  logic [5:0] read_index;

  modport source (output valid, cmd, char_code, is_release, read_index, input ready);
  modport sink   (input valid, cmd, char_code, is_release, read_index, output ready);
endinterface

// Result channel.
interface leb_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] caret;
  logic [5:0] text_length;
  logic [6:0] read_char;

  modport source (output valid, caret, text_length, read_char, input ready);
  modport sink   (input valid, caret, text_length, read_char, output ready);
endinterface

// Capacity register write channel.
interface leb_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[hdl/leb_ram.sv]
`timescale 1ns / 1ps

module leb_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/leb_front.sv]
`timescale 1ns / 1ps

module leb_front import leb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  leb_in_if.sink    keys,
  output leb_item_t q_item,
  output logic      q_valid,
  input  logic      q_ready
);

  leb_item_t  item_in;
  leb_item_t  entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  logic       printable;

  // Classify the key event; releases and unprintable inserts become no-ops.
  always_comb begin
    printable   = (keys.char_code >= CHAR_LO) && (keys.char_code <= CHAR_HI);
    item_in.ch  = keys.char_code;
    item_in.idx = keys.read_index;
    item_in.op  = OP_NOP;
    if (!keys.is_release) begin
      unique case (keys.cmd)
        CMD_INSERT: item_in.op = printable ? OP_INS : OP_NOP;
        CMD_HOME:   item_in.op = OP_HOME;
        CMD_END:    item_in.op = OP_END;
        CMD_LEFT:   item_in.op = OP_LEFT;
        CMD_RIGHT:  item_in.op = OP_RIGHT;
        CMD_BKSP:   item_in.op = OP_BKSP;
        CMD_DEL:    item_in.op = OP_DEL;
        CMD_READ:   item_in.op = OP_READ;
        default:    item_in.op = OP_NOP;
      endcase
    end
  end

  assign keys.ready = (count != 2'd2);
  assign push       = keys.valid && keys.ready;
  assign q_valid    = (count != 2'd0);
  assign pop        = q_valid && q_ready;
  assign q_item     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item_in;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[hdl/leb_back.sv]
`timescale 1ns / 1ps

module leb_back import leb_pkg::*; #(
  parameter int STORE_DEPTH = LEB_STORE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [6:0] capacity,
  input  leb_item_t  q_item,
  input  logic       q_valid,
  output logic       q_ready,
  leb_out_if.source  results
);

  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int CW     = (ADDR_W + 1 > 7) ? ADDR_W + 1 : 7;
  localparam int IDX_W  = (ADDR_W > 6) ? ADDR_W : 6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOVE,
    ST_FIN,
    ST_RDWAIT,
    ST_RESULT
  } state_t;

  state_t            state;
  leb_op_t           cur_op;
  logic [6:0]        cur_ch;
  logic [ADDR_W-1:0] caret;
  logic [ADDR_W-1:0] length;
  logic [ADDR_W-1:0] src;
  logic [ADDR_W-1:0] cnt;
  logic              dir_up;
  logic              pend;
  logic [ADDR_W-1:0] pend_addr;
  logic [6:0]        rchar;

  logic [CW-1:0]     cap_sat;
  logic [CW-1:0]     limit;
  logic              full;
  logic              idx_in_text;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [6:0]        ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [6:0]        ram_rdata;

  logic              out_valid;
  logic [5:0]        out_caret;
  logic [5:0]        out_len;
  logic [6:0]        out_char;

  // Text limit: capacity saturated to the store depth, zero treated as one, minus one.
  always_comb begin
    cap_sat = CW'(capacity);
    if (cap_sat > CW'(STORE_DEPTH)) begin
      cap_sat = CW'(STORE_DEPTH);
    end
    if (cap_sat == '0) begin
      cap_sat = CW'(1);
    end
    limit       = cap_sat - CW'(1);
    full        = CW'(length) >= limit;
    idx_in_text = IDX_W'(q_item.idx) < IDX_W'(length);
  end

  // One write port: pending shift beat first, then the inserted character.
  always_comb begin
    ram_we    = pend || (state == ST_FIN && cur_op == OP_INS);
    ram_waddr = pend ? pend_addr : caret;
    ram_wdata = pend ? ram_rdata : cur_ch;
    ram_raddr = (state == ST_MOVE) ? src : ADDR_W'(q_item.idx);
  end

  leb_ram #(
    .WIDTH (7),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign q_ready             = (state == ST_IDLE);
  assign results.valid       = out_valid;
  assign results.caret       = out_caret;
  assign results.text_length = out_len;
  assign results.read_char   = out_char;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      caret     <= '0;
      length    <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Drop a taken beat unless a new one loads in this cycle.
      if (out_valid && results.ready && state != ST_RESULT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cur_op <= q_item.op;
            cur_ch <= q_item.ch;
            rchar  <= '0;
            state  <= ST_RESULT;
            case (q_item.op)
              OP_HOME: caret <= '0;
              OP_END:  caret <= length;
              OP_LEFT: begin
                if (caret != '0) begin
                  caret <= caret - ADDR_W'(1);
                end
              end
              OP_RIGHT: begin
                if (caret < length) begin
                  caret <= caret + ADDR_W'(1);
                end
              end
              OP_INS: begin
                // Shift the tail up one place, top entry first.
                if (!full) begin
                  src    <= length - ADDR_W'(1);
                  cnt    <= length - caret;
                  dir_up <= 1'b0;
                  state  <= ST_MOVE;
                end
              end
              OP_BKSP: begin
                // Remove the entry before the caret: pull the tail down.
                if (caret != '0) begin
                  src    <= caret;
                  cnt    <= length - caret;
                  dir_up <= 1'b1;
                  state  <= ST_MOVE;
                end
              end
              OP_DEL: begin
                if (caret < length) begin
                  src    <= caret + ADDR_W'(1);
                  cnt    <= length - caret - ADDR_W'(1);
                  dir_up <= 1'b1;
                  state  <= ST_MOVE;
                end
              end
              OP_READ: begin
                if (idx_in_text) begin
                  state <= ST_RDWAIT;
                end
              end
              default: ;
            endcase
          end
        end
        ST_MOVE: begin
          // One entry read per cycle; its write lands the cycle after.
          if (cnt != '0) begin
            pend      <= 1'b1;
            pend_addr <= dir_up ? src - ADDR_W'(1) : src + ADDR_W'(1);
            src       <= dir_up ? src + ADDR_W'(1) : src - ADDR_W'(1);
            cnt       <= cnt - ADDR_W'(1);
          end else begin
            pend  <= 1'b0;
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          case (cur_op)
            OP_INS: begin
              length <= length + ADDR_W'(1);
              caret  <= caret + ADDR_W'(1);
            end
            OP_BKSP: begin
              length <= length - ADDR_W'(1);
              caret  <= caret - ADDR_W'(1);
            end
            default: length <= length - ADDR_W'(1);
          endcase
          state <= ST_RESULT;
        end
        ST_RDWAIT: begin
          rchar <= ram_rdata;
          state <= ST_RESULT;
        end
        ST_RESULT: begin
          if (!out_valid || results.ready) begin
            out_valid <= 1'b1;
            out_caret <= 6'(caret);
            out_len   <= 6'(length);
            out_char  <= rchar;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[hdl/line_edit_buffer_top.sv]
`timescale 1ns / 1ps

// Single-line text editor engine.
// keys: one beat per key event (cmd, char_code, is_release, read_index).
// results: one beat per key event, in order, with the caret and text length
//   after the event and, for a read, the character at read_index (0 beyond
//   the text or for any other event).
// cfg: one beat writes the capacity register; always ready. Write it only
//   while no key event is outstanding.
// Throughput: the front classifies a beat and queues it (two entries); the
//   back takes one event at a time. An insert, backspace or delete shifts
//   the store entries between the caret and the end of the text, one store
//   entry shifted per cycle through the single write port. Each result
//   beat leaves through the output register.
// Reset: caret and length clear, capacity returns to 64. The text store is
//   not cleared; only entries below the length are ever read.
// Stall: a stalled result holds in the output register; the back finishes
//   the next event and waits, and the queue fills before keys.ready drops.

module line_edit_buffer_top import leb_pkg::*; #(
  parameter int STORE_DEPTH = LEB_STORE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  leb_in_if.sink    keys,
  leb_out_if.source results,
  leb_cfg_if.sink   cfg
);

  logic [6:0] capacity;
  leb_item_t  q_item;
  logic       q_valid;
  logic       q_ready;

  // Capacity register: take every beat.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg.valid) begin
      capacity <= cfg.data;
    end
  end

  // Front: classify key beats and queue them.
  leb_front u_front (
    .clk     (clk),
    .rst     (rst),
    .keys    (keys),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_ready (q_ready)
  );

  // Back: edit the store, track caret and length, drive results.
  leb_back #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .capacity (capacity),
    .q_item   (q_item),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .results  (results)
  );

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
  import leb_pkg::*;

  // One key event as it is offered on the key channel.
  typedef struct packed {
    logic [2:0] cmd;
    logic [6:0] char_code;
    logic       is_release;
    logic [5:0] read_index;
  } keystroke_t;

  // One result beat: caret, length and the character read.
  typedef struct packed {
    logic [5:0] caret;
    logic [5:0] text_length;
    logic [6:0] read_char;
  } caret_report_t;

  // Cycles to let pass once every report is in, before a capacity write.
  localparam int SETTLE_CYCLES  = 8;
  // Wait at the end for late beats; the longest event in the back is a shift over the whole text.
  localparam int TAIL_CYCLES    = 80;
  // Cycles without any beat on any channel before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_GAP        = 12;
  localparam int PRINT_LIMIT    = 60;

  logic clk;
  logic rst;

  leb_in_if  keys_if ();
  leb_out_if res_if ();
  leb_cfg_if cfg_if ();

  line_edit_buffer_top dut (
    .clk     (clk),
    .rst     (rst),
    .keys    (keys_if),
    .results (res_if),
    .cfg     (cfg_if)
  );

  // Free-running clock, 12 ns period.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the editor: text, length, caret and the capacity register.
  // ---------------------------------------------------------------------------
  logic [6:0] line_text [LEB_STORE_DEPTH];
  int         line_len;
  int         line_caret;
  logic [6:0] line_cap;

  // Apply one key event to the shadow editor and return the report it causes.
  function automatic caret_report_t edit_line(keystroke_t k);
    caret_report_t r;
    int            limit;
    int            cut;
    int            i;
    r.read_char = '0;
    // Saturate capacity to the store depth; zero acts as one.
    limit = (int'(line_cap) > LEB_STORE_DEPTH) ? LEB_STORE_DEPTH : int'(line_cap);
    if (limit == 0) limit = 1;
    limit = limit - 1;
    if (!k.is_release) begin
      case (k.cmd)
        CMD_INSERT: begin
          // Drop non-printable characters and inserts into a full line.
          if (k.char_code >= CHAR_LO && k.char_code <= CHAR_HI && line_len < limit) begin
            for (i = line_len; i > line_caret; i--) line_text[i] = line_text[i - 1];
            line_text[line_caret] = k.char_code;
            line_len++;
            line_caret++;
          end
        end
        CMD_HOME:  line_caret = 0;
        CMD_END:   line_caret = line_len;
        CMD_LEFT:  if (line_caret > 0) line_caret--;
        CMD_RIGHT: if (line_caret < line_len) line_caret++;
        CMD_BKSP, CMD_DEL: begin
          // Backspace removes before the caret, delete at it; both land the
          // caret on the removed position.
          cut = (k.cmd == CMD_BKSP) ? line_caret - 1 : line_caret;
          if (cut >= 0 && cut < line_len) begin
            for (i = cut; i + 1 < line_len; i++) line_text[i] = line_text[i + 1];
            line_len--;
            line_caret = cut;
          end
        end
        default: begin
          if (int'(k.read_index) < line_len) r.read_char = line_text[k.read_index];
        end
      endcase
    end
    r.caret       = 6'(line_caret);
    r.text_length = 6'(line_len);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Bookkeeping shared by the stimulus, the driver and the monitor.
  // ---------------------------------------------------------------------------
  keystroke_t    keystrokes_pending [$];
  caret_report_t reports_due [$];
  int            keystrokes_queued;
  int            keystrokes_taken;
  int            mismatch_count;

  task automatic report_mismatch(string what);
    if (mismatch_count < PRINT_LIMIT) $display("[%0t] MISMATCH: %s", $time, what);
    mismatch_count++;
  endtask

  // Gap drawn per beat; burst mode gives stretches with no idling at all.
  function automatic int draw_gap(bit burst);
    return burst ? 0 : int'($urandom_range(MAX_GAP, 0));
  endfunction

  task automatic queue_key(logic [2:0] cmd, logic [6:0] ch, logic rel, logic [5:0] idx);
    keystroke_t k;
    k.cmd        = cmd;
    k.char_code  = ch;
    k.is_release = rel;
    k.read_index = idx;
    keystrokes_pending.push_back(k);
    keystrokes_queued++;
  endtask

  // Random key event. Mostly printable inserts and editing keys so the line
  // grows and shrinks; now and then any character code, a release, or a read
  // anywhere in the store.
  task automatic queue_random_key(int insert_pct);
    logic [2:0] cmd;
    logic [6:0] ch;
    logic [5:0] idx;
    cmd = ($urandom_range(99, 0) < insert_pct) ? CMD_INSERT : 3'($urandom_range(7, 1));
    ch  = ($urandom_range(9, 0) == 0) ? 7'($urandom_range(127, 0))
                                      : 7'($urandom_range(int'(CHAR_HI), int'(CHAR_LO)));
    idx = ($urandom_range(3, 0) == 0) ? 6'($urandom_range(63, 0))
                                      : 6'($urandom_range(line_len + 2, 0));
    queue_key(cmd, ch, ($urandom_range(19, 0) == 0), idx);
  endtask

  // Wait until every queued key is taken and every report is in, then settle.
  task automatic wait_drained();
    do @(posedge clk);
    while (keystrokes_taken != keystrokes_queued || reports_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the capacity register; update the shadow on the accepting edge.
  task automatic write_capacity(logic [6:0] value);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    do @(posedge clk);
    while (!(cfg_if.valid && cfg_if.ready));
    line_cap = value;
    cfg_if.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Key driver: hold a beat until taken, then idle for a drawn gap and
  // advance to the next pending key. Predict the report on acceptance.
  // ---------------------------------------------------------------------------
  keystroke_t key_cur;
  int         key_gap;
  bit         key_burst;

  always @(posedge clk) begin
    if (rst) begin
      keys_if.valid <= 1'b0;
      key_gap = 0;
      key_burst = 1'b0;
    end else begin
      if (keys_if.valid && keys_if.ready) begin
        reports_due.push_back(edit_line(key_cur));
        keystrokes_taken++;
        if ($urandom_range(39, 0) == 0) key_burst = !key_burst;
        key_gap = draw_gap(key_burst);
      end
      // Only move on once the current beat is gone; otherwise hold it.
      if (!keys_if.valid || keys_if.ready) begin
        if (key_gap > 0) begin
          key_gap--;
          keys_if.valid <= 1'b0;
        end else if (keystrokes_pending.size() > 0) begin
          key_cur = keystrokes_pending.pop_front();
          keys_if.valid      <= 1'b1;
          keys_if.cmd        <= key_cur.cmd;
          keys_if.char_code  <= key_cur.char_code;
          keys_if.is_release <= key_cur.is_release;
          keys_if.read_index <= key_cur.read_index;
        end else begin
          keys_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Report monitor: compare each taken beat with the oldest prediction, then
  // stall ready for a drawn number of cycles.
  // ---------------------------------------------------------------------------
  int res_gap;
  bit res_burst;

  always @(posedge clk) begin
    caret_report_t got;
    caret_report_t want;
    if (rst) begin
      res_if.ready <= 1'b0;
      res_gap = 0;
      res_burst = 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        got.caret       = res_if.caret;
        got.text_length = res_if.text_length;
        got.read_char   = res_if.read_char;
        if (reports_due.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing due: caret %0d len %0d char %0d",
                                    got.caret, got.text_length, got.read_char));
        end else begin
          want = reports_due.pop_front();
          if (got.caret !== want.caret)
            report_mismatch($sformatf("caret %0d, want %0d", got.caret, want.caret));
          if (got.text_length !== want.text_length)
            report_mismatch($sformatf("text_length %0d, want %0d",
                                      got.text_length, want.text_length));
          if (got.read_char !== want.read_char)
            report_mismatch($sformatf("read_char %0d, want %0d", got.read_char, want.read_char));
        end
        if ($urandom_range(39, 0) == 0) res_burst = !res_burst;
        res_gap = draw_gap(res_burst);
      end
      if (res_gap > 0) begin
        res_gap--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: count cycles with no beat on any channel.
  // ---------------------------------------------------------------------------
  int quiet_cycles;

  always @(posedge clk) begin
    if (rst || (keys_if.valid && keys_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no beat for %0d cycles", $time, quiet_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: reset, a directed pass, then random phases over several
  // capacities. Capacity only changes once the editor has drained.
  // ---------------------------------------------------------------------------
  initial begin
    logic [6:0] phase_cap [9];
    int         phase_insert_pct [9];
    int         phase_len [9];
    int         p;
    int         n;

    // Hold every input at a known value from time zero.
    rst                = 1'b1;
    keys_if.valid      = 1'b0;
    keys_if.cmd        = CMD_INSERT;
    keys_if.char_code  = '0;
    keys_if.is_release = 1'b0;
    keys_if.read_index = '0;
    res_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.data        = '0;
    keystrokes_queued  = 0;
    keystrokes_taken   = 0;
    mismatch_count     = 0;
    line_len           = 0;
    line_caret         = 0;
    line_cap           = CAP_RESET;
    foreach (line_text[i]) line_text[i] = '0;

    // Capacities cover zero, one, the store depth, above it, and a drop below
    // the current length right after the line has been filled.
    phase_cap        = '{7'd127, 7'd1, 7'd0, 7'd64, 7'd10, 7'd100, 7'd2, 7'd33, 7'd64};
    phase_insert_pct = '{50, 35, 35, 75, 45, 60, 40, 55, 50};
    phase_len        = '{55, 45, 45, 95, 50, 55, 45, 55, 55};

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    write_capacity(7'd64);

    // Empty line: read past the end, clamped moves and deletes.
    queue_key(CMD_READ,   7'd0,   1'b0, 6'd0);
    queue_key(CMD_BKSP,   7'd0,   1'b0, 6'd0);
    queue_key(CMD_DEL,    7'd0,   1'b0, 6'd0);
    queue_key(CMD_LEFT,   7'd0,   1'b0, 6'd0);
    queue_key(CMD_RIGHT,  7'd0,   1'b0, 6'd0);
    // Non-printable inserts are dropped; printable edges go in.
    queue_key(CMD_INSERT, 7'd31,  1'b0, 6'd0);
    queue_key(CMD_INSERT, 7'd127, 1'b0, 6'd63);
    queue_key(CMD_INSERT, 7'd0,   1'b0, 6'd0);
    queue_key(CMD_INSERT, 7'd32,  1'b0, 6'd0);
    queue_key(CMD_INSERT, 7'd126, 1'b0, 6'd0);
    // A release does nothing, not even for a read.
    queue_key(CMD_INSERT, 7'd65,  1'b1, 6'd0);
    queue_key(CMD_INSERT, 7'd97,  1'b0, 6'd0);
    queue_key(CMD_HOME,   7'd0,   1'b0, 6'd0);
    queue_key(CMD_INSERT, 7'd98,  1'b0, 6'd0);
    queue_key(CMD_RIGHT,  7'd0,   1'b0, 6'd0);
    queue_key(CMD_END,    7'd0,   1'b0, 6'd0);
    queue_key(CMD_RIGHT,  7'd0,   1'b0, 6'd0);
    queue_key(CMD_LEFT,   7'd0,   1'b0, 6'd0);
    queue_key(CMD_BKSP,   7'd0,   1'b0, 6'd0);
    queue_key(CMD_HOME,   7'd0,   1'b0, 6'd0);
    queue_key(CMD_DEL,    7'd0,   1'b0, 6'd0);
    queue_key(CMD_READ,   7'd0,   1'b0, 6'd0);
    queue_key(CMD_READ,   7'd0,   1'b1, 6'd1);
    queue_key(CMD_READ,   7'd0,   1'b0, 6'd1);
    queue_key(CMD_READ,   7'd0,   1'b0, 6'd63);
    wait_drained();

    for (p = 0; p < 9; p++) begin
      write_capacity(phase_cap[p]);
      for (n = 0; n < phase_len[p]; n++) queue_random_key(phase_insert_pct[p]);
      wait_drained();
    end

    // Catch any late or extra result beats.
    repeat (TAIL_CYCLES) @(posedge clk);
    while (reports_due.size() != 0) begin
      void'(reports_due.pop_front());
      report_mismatch("expected result never arrived");
    end

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
